>>> rtl/usfr_pkg.sv
package usfr_pkg;

    // operation codes of an input transaction
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_ARM    = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // event codes of a result transaction
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_RESP    = 3'd1;
    localparam logic [2:0] EV_SRC     = 3'd2;
    localparam logic [2:0] EV_IGNORED = 3'd3;
    localparam logic [2:0] EV_CSUM    = 3'd4;
    localparam logic [2:0] EV_UNKNOWN = 3'd5;

    // frame marker bytes
    localparam logic [7:0] RESP_START   = 8'hC2;
    localparam logic [7:0] NOTIF_START  = 8'h6E;
    localparam logic [7:0] NOTIF_TYPE   = 8'hDC;
    localparam logic [7:0] NOTIF_OPCODE = 8'h82;

    // response header size and notification length
    localparam int RESP_HDR_MIN = 8;
    localparam int NOTIF_BYTES  = 10;

    // parameter defaults
    localparam int RESP_CAPACITY_DEF = 32;
    localparam int NUM_SOURCES_DEF   = 4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [1:0] input_source;
        logic [7:0] resp_status;
        logic [7:0] resp_command;
        logic [7:0] resp_data_len;
        logic [7:0] resp_first_data;
    } result_t;

endpackage

>>> rtl/uart_scaler_frame_receiver.sv
// UART frame receiver for a display scaler link.
// Input channel (item_valid/item_ready/item): one transaction per received
// byte (op = byte) or per control event (op = arm capture, op = cancel).
// Output channel (res_valid/res_ready/res): exactly one result transaction
// per input transaction, in order, carrying the event code, the current
// video source and the kept response header bytes.
// Each result passes the input register, then the frame logic, then the
// result register before it is valid on res. Throughput is one transaction
// per cycle while the output side takes results.
// The frame logic is a single pass of compares and an 8-bit xor between the
// input register and the result register; its state sits beside it.
// Reset clears capture, both byte counters, the kept bytes and sets the
// source to 0. Nothing is pending after reset.
// When res_ready is low, the finished result waits in the result register
// and the input register takes a transaction only while it is empty;
// item_ready stays low while it is full, until the result is taken.
module uart_scaler_frame_receiver #(
    parameter int RESP_CAPACITY = usfr_pkg::RESP_CAPACITY_DEF,
    parameter int NUM_SOURCES   = usfr_pkg::NUM_SOURCES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  usfr_pkg::item_t   item,
    output logic              res_valid,
    input  logic              res_ready,
    output usfr_pkg::result_t res
);
    import usfr_pkg::*;

    localparam int CNT_W = $clog2(RESP_CAPACITY + 1);
    localparam int SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
    localparam int SRC_W = 9;

    localparam logic [CNT_W-1:0] RESP_CAP_C = CNT_W'(RESP_CAPACITY);
    localparam logic [CNT_W-1:0] IDX_STATUS = CNT_W'(2);
    localparam logic [CNT_W-1:0] IDX_CMD    = CNT_W'(3);
    localparam logic [CNT_W-1:0] IDX_LEN    = CNT_W'(6);
    localparam logic [CNT_W-1:0] IDX_DATA0  = CNT_W'(7);
    localparam logic [SUM_W-1:0] HDR_MIN_C  = SUM_W'(RESP_HDR_MIN);
    localparam logic [SRC_W-1:0] NUM_SRC_C  = SRC_W'(NUM_SOURCES);
    localparam logic [3:0]       NOTIF_LAST = 4'(NOTIF_BYTES - 1);

    // input stage
    logic  in_valid_reg;
    item_t in_data_reg;

    // result stage
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t out_data_next;

    // frame state
    logic             capture_open_reg,   capture_open_next;
    logic [CNT_W-1:0] resp_count_reg,     resp_count_next;
    logic [7:0]       resp_status_reg,    resp_status_next;
    logic [7:0]       resp_command_reg,   resp_command_next;
    logic [7:0]       resp_length_reg,    resp_length_next;
    logic [7:0]       resp_data_zero_reg, resp_data_zero_next;
    logic [3:0]       notif_count_reg,    notif_count_next;
    logic [7:0]       notif_xor_reg,      notif_xor_next;
    logic [7:0]       notif_type_reg,     notif_type_next;
    logic [7:0]       notif_opcode_reg,   notif_opcode_next;
    logic [7:0]       notif_source_reg,   notif_source_next;
    logic [1:0]       current_source_reg, current_source_next;

    logic             advance;
    logic [2:0]       ev;
    logic [CNT_W-1:0] cnt_inc;
    logic [SUM_W-1:0] cnt_ext;
    logic [SUM_W-1:0] len_need;
    logic [7:0]       b;

    // handshake: stage moves when the result register is free or drained
    assign advance    = in_valid_reg && (!out_valid_reg || res_ready);
    assign item_ready = !in_valid_reg || advance;
    assign res_valid  = out_valid_reg;
    assign res        = out_data_reg;
    assign b          = in_data_reg.rx_byte;

    // frame logic for the transaction in the input register
    always_comb
    begin
        capture_open_next   = capture_open_reg;
        resp_count_next     = resp_count_reg;
        resp_status_next    = resp_status_reg;
        resp_command_next   = resp_command_reg;
        resp_length_next    = resp_length_reg;
        resp_data_zero_next = resp_data_zero_reg;
        notif_count_next    = notif_count_reg;
        notif_xor_next      = notif_xor_reg;
        notif_type_next     = notif_type_reg;
        notif_opcode_next   = notif_opcode_reg;
        notif_source_next   = notif_source_reg;
        current_source_next = current_source_reg;
        ev                  = EV_NONE;
        cnt_inc             = resp_count_reg;
        cnt_ext             = '0;
        len_need            = '0;

        unique case (in_data_reg.op)
            OP_BYTE:
            begin
                if (capture_open_reg)
                begin
                    // response capture: hunt for start, then count
                    if (resp_count_reg != '0 || b == RESP_START)
                    begin
                        if (resp_count_reg < RESP_CAP_C)
                        begin
                            if (resp_count_reg == IDX_STATUS)
                            begin
                                resp_status_next = b;
                            end
                            if (resp_count_reg == IDX_CMD)
                            begin
                                resp_command_next = b;
                            end
                            if (resp_count_reg == IDX_LEN)
                            begin
                                resp_length_next = b;
                            end
                            if (resp_count_reg == IDX_DATA0)
                            begin
                                resp_data_zero_next = b;
                            end
                            cnt_inc = resp_count_reg + CNT_W'(1);
                        end
                        resp_count_next = cnt_inc;
                        cnt_ext  = SUM_W'(cnt_inc);
                        len_need = HDR_MIN_C + SUM_W'(resp_length_next);
                        if (cnt_ext >= HDR_MIN_C && cnt_ext >= len_need)
                        begin
                            capture_open_next = 1'b0;
                            ev = EV_RESP;
                        end
                    end
                end
                else
                begin
                    // notification assembly
                    if (notif_count_reg == '0)
                    begin
                        if (b == NOTIF_START)
                        begin
                            notif_xor_next   = b;
                            notif_count_next = 4'd1;
                        end
                    end
                    else if (notif_count_reg < NOTIF_LAST)
                    begin
                        if (notif_count_reg == 4'd5)
                        begin
                            notif_type_next = b;
                        end
                        if (notif_count_reg == 4'd6)
                        begin
                            notif_opcode_next = b;
                        end
                        if (notif_count_reg == 4'd8)
                        begin
                            notif_source_next = b;
                        end
                        notif_xor_next   = notif_xor_reg ^ b;
                        notif_count_next = notif_count_reg + 4'd1;
                    end
                    else
                    begin
                        notif_count_next = '0;
                        if (notif_type_reg != NOTIF_TYPE || notif_opcode_reg != NOTIF_OPCODE)
                        begin
                            ev = EV_IGNORED;
                        end
                        else if (notif_xor_reg != b)
                        begin
                            ev = EV_CSUM;
                        end
                        else if (SRC_W'(notif_source_reg) >= NUM_SRC_C)
                        begin
                            ev = EV_UNKNOWN;
                        end
                        else
                        begin
                            current_source_next = notif_source_reg[1:0];
                            ev = EV_SRC;
                        end
                    end
                end
            end
            OP_ARM:
            begin
                capture_open_next = 1'b1;
                resp_count_next   = '0;
            end
            OP_CANCEL:
            begin
                capture_open_next = 1'b0;
            end
            default:
            begin
                ev = EV_NONE;
            end
        endcase

        out_data_next.event_res       = ev;
        out_data_next.input_source    = current_source_next;
        out_data_next.resp_status     = resp_status_next;
        out_data_next.resp_command    = resp_command_next;
        out_data_next.resp_data_len   = resp_length_next;
        out_data_next.resp_first_data = resp_data_zero_next;
    end

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            capture_open_reg   <= 1'b0;
            resp_count_reg     <= '0;
            resp_status_reg    <= '0;
            resp_command_reg   <= '0;
            resp_length_reg    <= '0;
            resp_data_zero_reg <= '0;
            notif_count_reg    <= '0;
            notif_xor_reg      <= '0;
            notif_type_reg     <= '0;
            notif_opcode_reg   <= '0;
            notif_source_reg   <= '0;
            current_source_reg <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                capture_open_reg   <= capture_open_next;
                resp_count_reg     <= resp_count_next;
                resp_status_reg    <= resp_status_next;
                resp_command_reg   <= resp_command_next;
                resp_length_reg    <= resp_length_next;
                resp_data_zero_reg <= resp_data_zero_next;
                notif_count_reg    <= notif_count_next;
                notif_xor_reg      <= notif_xor_next;
                notif_type_reg     <= notif_type_next;
                notif_opcode_reg   <= notif_opcode_next;
                notif_source_reg   <= notif_source_next;
                current_source_reg <= current_source_next;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_data_reg <= item;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
